>>> hdl/nbe_pkg.sv
`timescale 1ns / 1ps

package nbe_pkg;

   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_TIME_STEP = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FROZEN    = 4'd1;

   localparam logic CMD_ADD  = 1'b0;
   localparam logic CMD_STEP = 1'b1;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_COINC = 2'd2;
   localparam logic [1:0] ST_SAT   = 2'd3;

   localparam logic [15:0] TIME_STEP_RESET = 16'd655;

   // iteration counts of the shared divide / square root unit
   localparam logic [6:0] SQRT_STEPS     = 7'd32;
   localparam logic [6:0] QDIV_STEPS     = 7'd75;   // 27 + 48
   localparam logic [6:0] QDIV_STEPS_E   = 7'd73;   // 27 + 46
   localparam logic [6:0] TDIV_STEPS     = 7'd63;

   typedef struct packed {
      logic               command;
      logic signed [31:0] start_x;
      logic signed [31:0] start_y;
      logic signed [31:0] start_vx;
      logic signed [31:0] start_vy;
      logic [6:0]         surface_gravity;
      logic [9:0]         body_radius;
   } nbe_req_type;

   typedef struct packed {
      logic [5:0]         body_index;
      logic signed [31:0] new_x;
      logic signed [31:0] new_y;
      logic signed [31:0] new_vx;
      logic signed [31:0] new_vy;
      logic [1:0]         status;
      logic               last;
   } nbe_rsp_type;

   typedef struct packed {
      logic       start;
      logic       is_sqrt;
      logic [6:0] steps;
   } nbe_iter_cmd_type;

   typedef struct packed {
      logic        busy;
      logic [31:0] quo;
      logic        over;
   } nbe_iter_res_type;

endpackage

>>> hdl/nbe_iter_unit.sv
`timescale 1ns / 1ps

// Restoring divide / digit-by-digit square root on one compare-subtract.
// Dividend or radicand is loaded left-aligned in num_in.
module nbe_iter_unit import nbe_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  nbe_iter_cmd_type cmd,
   input  logic [79:0]      num_in,
   input  logic [63:0]      den_in,
   output nbe_iter_res_type res
);

   logic        busy_ff;
   logic        sqrt_ff;
   logic [6:0]  cnt_ff;
   logic [65:0] rem_ff;
   logic [79:0] num_ff;
   logic [63:0] den_ff;
   logic [31:0] quo_ff;
   logic        over_ff;

   logic [65:0] shifted;
   logic [65:0] operand;
   logic [65:0] diff;
   logic        ge;

   always_comb begin
      if (sqrt_ff) begin
         shifted = {rem_ff[63:0], num_ff[79:78]};
         operand = {32'd0, quo_ff, 2'b01};
      end else begin
         shifted = {rem_ff[64:0], num_ff[79]};
         operand = {2'b00, den_ff};
      end
      ge   = (shifted >= operand);
      diff = shifted - operand;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (cmd.start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= cmd.steps;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         sqrt_ff <= cmd.is_sqrt;
         rem_ff  <= '0;
         num_ff  <= num_in;
         den_ff  <= den_in;
         quo_ff  <= '0;
         over_ff <= 1'b0;
      end else if (busy_ff) begin
         rem_ff  <= ge ? diff : shifted;
         num_ff  <= sqrt_ff ? {num_ff[77:0], 2'b00} : {num_ff[78:0], 1'b0};
         quo_ff  <= {quo_ff[30:0], ge};
         // a one shifted out of the top means the quotient passed 32 bits
         over_ff <= over_ff | quo_ff[31];
      end
   end

   assign res.busy = busy_ff;
   assign res.quo  = quo_ff;
   assign res.over = over_ff;

endmodule

>>> hdl/nbody_gravity_euler_step.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_ready  nbe_req_type: command and new body
// rsp_      out        rsp_valid / rsp_ready  nbe_rsp_type: one body per transfer
// csr_      in         csr_valid / csr_ready  csr_index, csr_data (always ready)
//
// Add: result registered in the cycle after the command is accepted.
// Step: per body, for each other body at a distinct position a square root, a quotient
//   and two divides, all on one shared iteration unit.
//   Frozen step: each body is reported unchanged with status OK.
// Reset: clears control and body count and resets the CSRs; the body tables are not cleared.
// req_ready is low while a command is in progress or a result waits for transfer.
module nbody_gravity_euler_step import nbe_pkg::*; #(
   parameter int MAX_BODIES = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  nbe_req_type           req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output nbe_rsp_type           rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int IDX_W = $clog2(MAX_BODIES);
   localparam int CNT_W = $clog2(MAX_BODIES + 1);

   typedef enum logic [4:0] {
      S_IDLE, S_RD_I, S_GET_I, S_J_TEST, S_GET_J, S_MUL_U, S_MUL_W, S_D_SUM,
      S_SQ_START, S_SQ_WAIT, S_DV_START, S_DV_WAIT, S_MUL_QU, S_T1_START,
      S_T1_WAIT, S_MUL_QW, S_T2_START, S_T2_WAIT, S_UPD_AX, S_UPD_AY,
      S_UPD_PX, S_UPD_PY, S_UPD_PYW, S_WB, S_EMIT
   } state_type;

   function automatic logic signed [31:0] clamp32(input logic signed [39:0] v);
      if (v > 40'sd2147483647) begin
         clamp32 = 32'sh7FFFFFFF;
      end else if (v < -40'sd2147483648) begin
         clamp32 = 32'sh80000000;
      end else begin
         clamp32 = v[31:0];
      end
   endfunction

   function automatic logic ovf32(input logic signed [39:0] v);
      ovf32 = (v > 40'sd2147483647) || (v < -40'sd2147483648);
   endfunction

   // body tables
   logic signed [31:0] px_mem [MAX_BODIES];
   logic signed [31:0] py_mem [MAX_BODIES];
   logic signed [31:0] vx_mem [MAX_BODIES];
   logic signed [31:0] vy_mem [MAX_BODIES];
   logic [26:0]        s_mem  [MAX_BODIES];

   logic signed [31:0] rd_px_ff, rd_py_ff, rd_vx_ff, rd_vy_ff;
   logic [26:0]        rd_s_ff;
   logic [IDX_W-1:0]   rd_addr;

   state_type          state_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [CNT_W-1:0]   i_ff;
   logic [CNT_W-1:0]   j_ff;
   logic [15:0]        time_step_ff;
   logic               frozen_ff;
   logic               rsp_valid_ff;
   nbe_rsp_type        rsp_data_ff;

   logic signed [31:0] pix_ff, piy_ff, vix_ff, viy_ff;
   logic [30:0]        u_ff, w_ff;
   logic               e_ff, sx_ff, sy_ff;
   logic [26:0]        s_ff;
   logic [63:0]        d_ff;
   logic [31:0]        r_ff, q_ff;
   logic signed [39:0] acc_x_ff, acc_y_ff;
   logic               sat_ff, coinc_ff;

   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] prod_ff;

   nbe_iter_cmd_type   iter_cmd;
   logic [79:0]        iter_num;
   logic [63:0]        iter_den;
   nbe_iter_res_type   iter_res;

   logic               req_take;
   logic               emit_go;
   logic               rsp_load;
   logic               add_full;
   logic [26:0]        s_new;
   logic signed [32:0] dx, dy;
   logic [32:0]        ux_abs, wy_abs;
   logic               e_new;
   logic signed [31:0] ax_c, ay_c;
   logic signed [32:0] scaled;
   logic signed [39:0] v_sum_x, v_sum_y, p_sum_x, p_sum_y;
   logic signed [39:0] term40;
   logic [1:0]         st_code;

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign emit_go   = (state_ff == S_EMIT) && (!rsp_valid_ff || rsp_ready);
   assign rsp_load  = (req_take && req_data.command == CMD_ADD) || emit_go;
   assign add_full  = (cnt_ff >= CNT_W'(MAX_BODIES));
   assign s_new     = 27'(req_data.surface_gravity) * 27'(req_data.body_radius)
                      * 27'(req_data.body_radius);

   assign dx     = {rd_px_ff[31], rd_px_ff} - {pix_ff[31], pix_ff};
   assign dy     = {rd_py_ff[31], rd_py_ff} - {piy_ff[31], piy_ff};
   assign ux_abs = dx[32] ? 33'(-dx) : 33'(dx);
   assign wy_abs = dy[32] ? 33'(-dy) : 33'(dy);
   // halve both when either difference reaches 2^31
   assign e_new  = ux_abs[31] | wy_abs[31];

   assign ax_c    = clamp32(acc_x_ff);
   assign ay_c    = clamp32(acc_y_ff);
   assign scaled  = prod_ff[48:16];   // floor(x * dt / 2^16)
   assign v_sum_x = {{8{vix_ff[31]}}, vix_ff} + {{7{scaled[32]}}, scaled};
   assign v_sum_y = {{8{viy_ff[31]}}, viy_ff} + {{7{scaled[32]}}, scaled};
   assign p_sum_x = {{8{pix_ff[31]}}, pix_ff} + {{7{scaled[32]}}, scaled};
   assign p_sum_y = {{8{piy_ff[31]}}, piy_ff} + {{7{scaled[32]}}, scaled};
   assign term40  = {8'd0, iter_res.quo};

   always_comb begin
      if (frozen_ff) begin
         st_code = ST_OK;
      end else if (sat_ff) begin
         st_code = ST_SAT;
      end else if (coinc_ff) begin
         st_code = ST_COINC;
      end else begin
         st_code = ST_OK;
      end
   end

   assign rd_addr = (state_ff == S_RD_I) ? i_ff[IDX_W-1:0] : j_ff[IDX_W-1:0];

   always_ff @(posedge clock) begin
      rd_px_ff <= px_mem[rd_addr];
      rd_py_ff <= py_mem[rd_addr];
      rd_vx_ff <= vx_mem[rd_addr];
      rd_vy_ff <= vy_mem[rd_addr];
      rd_s_ff  <= s_mem[rd_addr];
      if (req_take && req_data.command == CMD_ADD && !add_full) begin
         px_mem[cnt_ff[IDX_W-1:0]] <= req_data.start_x;
         py_mem[cnt_ff[IDX_W-1:0]] <= req_data.start_y;
         vx_mem[cnt_ff[IDX_W-1:0]] <= req_data.start_vx;
         vy_mem[cnt_ff[IDX_W-1:0]] <= req_data.start_vy;
         s_mem[cnt_ff[IDX_W-1:0]]  <= s_new;
      end else if (state_ff == S_WB) begin
         px_mem[i_ff[IDX_W-1:0]] <= pix_ff;
         py_mem[i_ff[IDX_W-1:0]] <= piy_ff;
         vx_mem[i_ff[IDX_W-1:0]] <= vix_ff;
         vy_mem[i_ff[IDX_W-1:0]] <= viy_ff;
      end
   end

   // shared multiplier, one product per cycle
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_MUL_U: begin
            mul_a = {2'b00, u_ff};
            mul_b = {2'b00, u_ff};
         end
         S_MUL_W: begin
            mul_a = {2'b00, w_ff};
            mul_b = {2'b00, w_ff};
         end
         S_MUL_QU: begin
            mul_a = {1'b0, q_ff};
            mul_b = {2'b00, u_ff};
         end
         S_MUL_QW: begin
            mul_a = {1'b0, q_ff};
            mul_b = {2'b00, w_ff};
         end
         S_UPD_AX: begin
            mul_a = {ax_c[31], ax_c};
            mul_b = {17'd0, time_step_ff};
         end
         S_UPD_AY: begin
            mul_a = {ay_c[31], ay_c};
            mul_b = {17'd0, time_step_ff};
         end
         S_UPD_PX: begin
            mul_a = {vix_ff[31], vix_ff};
            mul_b = {17'd0, time_step_ff};
         end
         S_UPD_PY: begin
            mul_a = {viy_ff[31], viy_ff};
            mul_b = {17'd0, time_step_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   always_comb begin
      iter_cmd = '0;
      iter_num = '0;
      iter_den = '0;
      unique case (state_ff)
         S_SQ_START: begin
            iter_cmd = '{start: 1'b1, is_sqrt: 1'b1, steps: SQRT_STEPS};
            iter_num = {d_ff, 16'd0};
         end
         S_DV_START: begin
            iter_cmd = '{start: 1'b1, is_sqrt: 1'b0,
                         steps: (e_ff ? QDIV_STEPS_E : QDIV_STEPS)};
            iter_num = {s_ff, 53'd0};
            iter_den = d_ff;
         end
         S_T1_START, S_T2_START: begin
            iter_cmd = '{start: 1'b1, is_sqrt: 1'b0, steps: TDIV_STEPS};
            iter_num = {prod_ff[62:0], 17'd0};
            iter_den = {32'd0, r_ff};
         end
         default: begin
            iter_cmd = '0;
         end
      endcase
   end

   nbe_iter_unit u_iter (
      .clock  (clock),
      .reset  (reset),
      .cmd    (iter_cmd),
      .num_in (iter_num),
      .den_in (iter_den),
      .res    (iter_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff <= TIME_STEP_RESET;
         frozen_ff    <= 1'b0;
      end else if (csr_valid) begin
         if (csr_index == CSR_TIME_STEP) begin
            time_step_ff <= csr_data;
         end else if (csr_index == CSR_FROZEN) begin
            frozen_ff <= csr_data[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_take) begin
                  if (req_data.command == CMD_ADD) begin
                     rsp_data_ff.last <= 1'b1;
                     if (add_full) begin
                        rsp_data_ff.body_index <= '0;
                        rsp_data_ff.new_x      <= '0;
                        rsp_data_ff.new_y      <= '0;
                        rsp_data_ff.new_vx     <= '0;
                        rsp_data_ff.new_vy     <= '0;
                        rsp_data_ff.status     <= ST_FULL;
                     end else begin
                        rsp_data_ff.body_index <= 6'(cnt_ff);
                        rsp_data_ff.new_x      <= req_data.start_x;
                        rsp_data_ff.new_y      <= req_data.start_y;
                        rsp_data_ff.new_vx     <= req_data.start_vx;
                        rsp_data_ff.new_vy     <= req_data.start_vy;
                        rsp_data_ff.status     <= ST_OK;
                        cnt_ff <= cnt_ff + CNT_W'(1);
                     end
                  end else if (cnt_ff != '0) begin
                     i_ff     <= '0;
                     state_ff <= S_RD_I;
                  end
               end
            end
            S_RD_I: begin
               state_ff <= S_GET_I;
            end
            S_GET_I: begin
               pix_ff   <= rd_px_ff;
               piy_ff   <= rd_py_ff;
               vix_ff   <= rd_vx_ff;
               viy_ff   <= rd_vy_ff;
               acc_x_ff <= '0;
               acc_y_ff <= '0;
               sat_ff   <= 1'b0;
               coinc_ff <= 1'b0;
               j_ff     <= '0;
               state_ff <= frozen_ff ? S_EMIT : S_J_TEST;
            end
            S_J_TEST: begin
               if (j_ff == cnt_ff) begin
                  state_ff <= S_UPD_AX;
               end else if (j_ff == i_ff) begin
                  j_ff <= j_ff + CNT_W'(1);
               end else begin
                  state_ff <= S_GET_J;
               end
            end
            S_GET_J: begin
               if (dx == '0 && dy == '0) begin
                  coinc_ff <= 1'b1;
                  j_ff     <= j_ff + CNT_W'(1);
                  state_ff <= S_J_TEST;
               end else begin
                  u_ff     <= e_new ? ux_abs[31:1] : ux_abs[30:0];
                  w_ff     <= e_new ? wy_abs[31:1] : wy_abs[30:0];
                  e_ff     <= e_new;
                  sx_ff    <= dx[32];
                  sy_ff    <= dy[32];
                  s_ff     <= rd_s_ff;
                  state_ff <= S_MUL_U;
               end
            end
            S_MUL_U: begin
               state_ff <= S_MUL_W;
            end
            S_MUL_W: begin
               d_ff     <= prod_ff[63:0];
               state_ff <= S_D_SUM;
            end
            S_D_SUM: begin
               d_ff     <= d_ff + prod_ff[63:0];
               state_ff <= S_SQ_START;
            end
            S_SQ_START: begin
               state_ff <= S_SQ_WAIT;
            end
            S_SQ_WAIT: begin
               if (!iter_res.busy) begin
                  r_ff     <= iter_res.quo;
                  state_ff <= S_DV_START;
               end
            end
            S_DV_START: begin
               state_ff <= S_DV_WAIT;
            end
            S_DV_WAIT: begin
               if (!iter_res.busy) begin
                  q_ff     <= iter_res.over ? 32'hFFFFFFFF : iter_res.quo;
                  sat_ff   <= sat_ff | iter_res.over;
                  state_ff <= S_MUL_QU;
               end
            end
            S_MUL_QU: begin
               state_ff <= S_T1_START;
            end
            S_T1_START: begin
               state_ff <= S_T1_WAIT;
            end
            S_T1_WAIT: begin
               if (!iter_res.busy) begin
                  acc_x_ff <= sx_ff ? acc_x_ff - term40 : acc_x_ff + term40;
                  state_ff <= S_MUL_QW;
               end
            end
            S_MUL_QW: begin
               state_ff <= S_T2_START;
            end
            S_T2_START: begin
               state_ff <= S_T2_WAIT;
            end
            S_T2_WAIT: begin
               if (!iter_res.busy) begin
                  acc_y_ff <= sy_ff ? acc_y_ff - term40 : acc_y_ff + term40;
                  j_ff     <= j_ff + CNT_W'(1);
                  state_ff <= S_J_TEST;
               end
            end
            S_UPD_AX: begin
               sat_ff   <= sat_ff | ovf32(acc_x_ff) | ovf32(acc_y_ff);
               state_ff <= S_UPD_AY;
            end
            S_UPD_AY: begin
               vix_ff   <= clamp32(v_sum_x);
               sat_ff   <= sat_ff | ovf32(v_sum_x);
               state_ff <= S_UPD_PX;
            end
            S_UPD_PX: begin
               viy_ff   <= clamp32(v_sum_y);
               sat_ff   <= sat_ff | ovf32(v_sum_y);
               state_ff <= S_UPD_PY;
            end
            S_UPD_PY: begin
               pix_ff   <= clamp32(p_sum_x);
               sat_ff   <= sat_ff | ovf32(p_sum_x);
               state_ff <= S_UPD_PYW;
            end
            S_UPD_PYW: begin
               piy_ff   <= clamp32(p_sum_y);
               sat_ff   <= sat_ff | ovf32(p_sum_y);
               state_ff <= S_WB;
            end
            S_WB: begin
               state_ff <= S_EMIT;
            end
            S_EMIT: begin
               if (emit_go) begin
                  rsp_data_ff.body_index <= 6'(i_ff);
                  rsp_data_ff.new_x      <= pix_ff;
                  rsp_data_ff.new_y      <= piy_ff;
                  rsp_data_ff.new_vx     <= vix_ff;
                  rsp_data_ff.new_vy     <= viy_ff;
                  rsp_data_ff.status     <= st_code;
                  rsp_data_ff.last       <= ((i_ff + CNT_W'(1)) == cnt_ff);
                  if ((i_ff + CNT_W'(1)) == cnt_ff) begin
                     state_ff <= S_IDLE;
                  end else begin
                     i_ff     <= i_ff + CNT_W'(1);
                     state_ff <= S_RD_I;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_BODIES))
      else $error("body count above table size");

   a_iter_start_idle: assert property (@(posedge clock) disable iff (reset)
      iter_cmd.start |-> !iter_res.busy)
      else $error("iteration unit restarted while busy");

   a_emit_index: assert property (@(posedge clock) disable iff (reset)
      emit_go |-> (i_ff < cnt_ff))
      else $error("reported body beyond body count");

   a_take_no_pending: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff != S_IDLE) || rsp_valid_ff || $past(req_data.command) == CMD_STEP)
      else $error("add transfer produced no result");

endmodule
